/* design/servo_packet_deframer_top_defines.svh */
// Assertion macros used by the deframer top level.
`ifndef SERVO_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define SERVO_PACKET_DEFRAMER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checks cons in the same cycle as ante.
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Checks cons in the cycle after ante.
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/spd_pkg.sv */
package spd_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [15:0] byte_index;
    logic [2:0]  status;
    logic [15:0] packet_bytes;
  } out_item_t;

  localparam logic [7:0] HDR_FF = 8'hFF;
  localparam logic [7:0] HDR_FD = 8'hFD;

  localparam logic [16:0] FRAME_OVERHEAD = 17'd7;
  localparam logic [15:0] MIN_LENGTH     = 16'd3;
  localparam logic [16:0] MIN_TOTAL      = 17'd10;

  localparam logic [15:0] LEN_LO_INDEX = 16'd5;
  localparam logic [15:0] LEN_HI_INDEX = 16'd6;

  localparam logic [15:0] BUF_SIZE_RESET = 16'd255;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_DISCARD  = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

endpackage

/* design/spd_in_stage.sv */
module spd_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  spd_pkg::in_item_t in_data,
  input  logic             take,
  output logic             stage_valid,
  output spd_pkg::in_item_t stage_item
);
  import spd_pkg::*;

  // The register may refill in the same cycle that its item moves on.
  assign in_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

endmodule

/* design/spd_core.sv */
module spd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  spd_pkg::in_item_t  item,
  input  logic [15:0]       buf_size,
  output spd_pkg::out_item_t result
);
  import spd_pkg::*;

  localparam logic [1:0] PH_HUNT0 = 2'd0;
  localparam logic [1:0] PH_HUNT1 = 2'd1;
  localparam logic [1:0] PH_HUNT2 = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [15:0] byte_count;
  logic [15:0] byte_count_next;
  logic [15:0] length_field;
  logic [15:0] length_field_next;

  logic [16:0] count_inc;
  logic [15:0] eff_len;
  logic [16:0] full_len;

  // A packet can only end at its tenth byte or later, so the length bytes are
  // already in the register by the time the total is compared.
  assign count_inc = {1'b0, byte_count} + 17'd1;
  assign eff_len   = (length_field < MIN_LENGTH) ? MIN_LENGTH : length_field;
  assign full_len  = {1'b0, eff_len} + FRAME_OVERHEAD;

  always_comb begin
    phase_next        = phase;
    byte_count_next   = count_inc[15:0];
    length_field_next = length_field;
    result.byte_out     = item.rx_byte;
    result.byte_index   = byte_count;
    result.status       = ST_STORED;
    result.packet_bytes = 16'd0;

    if (item.func) begin
      phase_next          = PH_HUNT0;
      byte_count_next     = 16'd0;
      length_field_next   = 16'd0;
      result.byte_out     = 8'd0;
      result.byte_index   = 16'd0;
      result.status       = ST_TIMEOUT;
    end else if (count_inc >= {1'b0, buf_size}) begin
      // The capacity test wins over every outcome but a timeout.
      phase_next        = PH_HUNT0;
      byte_count_next   = 16'd0;
      length_field_next = 16'd0;
      result.status     = ST_OVERFLOW;
    end else begin
      case (phase)
        PH_HUNT0, PH_HUNT1: begin
          if (item.rx_byte == HDR_FF) begin
            phase_next = (phase == PH_HUNT0) ? PH_HUNT1 : PH_HUNT2;
          end else begin
            phase_next        = PH_HUNT0;
            byte_count_next   = 16'd0;
            length_field_next = 16'd0;
            result.status     = ST_DISCARD;
          end
        end
        PH_HUNT2: begin
          if (item.rx_byte == HDR_FD) begin
            phase_next = PH_BODY;
          end else begin
            phase_next        = PH_HUNT0;
            byte_count_next   = 16'd0;
            length_field_next = 16'd0;
            result.status     = ST_DISCARD;
          end
        end
        default: begin
          if (byte_count == LEN_LO_INDEX) begin
            length_field_next = {8'd0, item.rx_byte};
          end else if (byte_count == LEN_HI_INDEX) begin
            length_field_next = {item.rx_byte, length_field[7:0]};
          end
          if (count_inc >= MIN_TOTAL && count_inc == full_len) begin
            result.status       = ST_COMPLETE;
            result.packet_bytes = count_inc[15:0];
            phase_next          = PH_HUNT0;
            byte_count_next     = 16'd0;
            length_field_next   = 16'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT0;
      byte_count   <= 16'd0;
      length_field <= 16'd0;
    end else if (advance) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      length_field <= length_field_next;
    end
  end

endmodule

/* design/spd_out_stage.sv */
module spd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               stage_valid,
  input  spd_pkg::out_item_t  result,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output spd_pkg::out_item_t  out_data
);
  import spd_pkg::*;

  assign take = stage_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

endmodule

/* design/servo_packet_deframer_top.sv */
// An accepted item waits in the input register; its result is registered in the output register
// when the output is not stalled. The input register refills while its item moves on.
// Throughput: one item per cycle unless the output stalls.
// A stalled result holds in the output register while one more item waits in the input register.
// Synchronous active-high reset empties both registers, returns to header hunting
// and sets the buffer size to 255.
module servo_packet_deframer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spd_pkg::in_item_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spd_pkg::out_item_t  out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import spd_pkg::*;
  `include "servo_packet_deframer_top_defines.svh"

  logic [15:0] buffer_size;
  logic       stage_valid;
  logic       take;
  in_item_t   stage_item;
  out_item_t  result;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUF_SIZE_RESET;
    end else if (cfg_we) begin
      buffer_size <= cfg_wdata;
    end
  end

  spd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .stage_valid(stage_valid),
    .stage_item (stage_item)
  );

  spd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (take),
    .item    (stage_item),
    .buf_size(buffer_size),
    .result  (result)
  );

  spd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .stage_valid(stage_valid),
    .result     (result),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `SPD_ASSERT_NOW(a_pkt_bytes_zero, clk, rst, out_valid && (out_data.status != ST_COMPLETE), out_data.packet_bytes == 16'd0, "packet_bytes set on a result that is not complete")
  `SPD_ASSERT_NOW(a_timeout_clear, clk, rst, out_valid && (out_data.status == ST_TIMEOUT), (out_data.byte_out == 8'd0) && (out_data.byte_index == 16'd0), "timeout result carries byte data")
  `SPD_ASSERT_NOW(a_complete_total, clk, rst, out_valid && (out_data.status == ST_COMPLETE), (out_data.packet_bytes >= 16'd10) && (out_data.byte_index + 16'd1 == out_data.packet_bytes), "complete packet total does not match its last index")
  `SPD_ASSERT_NEXT(a_stall_holds_stage, clk, rst, stage_valid && out_valid && !out_ready, stage_valid, "waiting item lost while output stalled")

endmodule

/* tb/servo_packet_deframer_checker.sv */
`timescale 1ns / 1ps

module servo_packet_deframer_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  spd_pkg::in_item_t   in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  spd_pkg::out_item_t  out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 mismatches,
  output int                 awaiting,
  output int                 checked,
  output int                 completed
);
  import spd_pkg::*;

  typedef enum logic [1:0] {HUNT_FF1, HUNT_FF2, HUNT_FD, IN_BODY} hunt_state_t;

  hunt_state_t hunt_state;
  logic [16:0] stored;
  logic [15:0] pkt_len;
  logic [15:0] capacity;
  out_item_t   predicted_echoes [$];

  function automatic void restart_hunt();
    hunt_state = HUNT_FF1;
    stored     = '0;
    pkt_len    = '0;
  endfunction

  // Works out the echo for one item and advances the frame state.
  function automatic out_item_t deframe(in_item_t it);
    out_item_t   r;
    logic [15:0] eff_len;
    logic [16:0] need;
    r = '0;
    if (it.func) begin
      restart_hunt();
      r.status = ST_TIMEOUT;
      return r;
    end
    r.byte_out   = it.rx_byte;
    r.byte_index = stored[15:0];
    r.status     = ST_STORED;
    stored       = stored + 17'd1;
    // The capacity test wins over every outcome but a timeout.
    if (stored >= {1'b0, capacity}) begin
      r.status = ST_OVERFLOW;
      restart_hunt();
    end else begin
      case (hunt_state)
        HUNT_FF1: begin
          if (it.rx_byte == HDR_FF) hunt_state = HUNT_FF2;
          else begin
            r.status = ST_DISCARD;
            restart_hunt();
          end
        end
        HUNT_FF2: begin
          if (it.rx_byte == HDR_FF) hunt_state = HUNT_FD;
          else begin
            r.status = ST_DISCARD;
            restart_hunt();
          end
        end
        HUNT_FD: begin
          if (it.rx_byte == HDR_FD) hunt_state = IN_BODY;
          else begin
            r.status = ST_DISCARD;
            restart_hunt();
          end
        end
        default: begin
          if (r.byte_index == LEN_LO_INDEX) pkt_len = {8'h00, it.rx_byte};
          else if (r.byte_index == LEN_HI_INDEX) pkt_len = {it.rx_byte, pkt_len[7:0]};
          eff_len = (pkt_len < MIN_LENGTH) ? MIN_LENGTH : pkt_len;
          need = {1'b0, eff_len} + FRAME_OVERHEAD;
          if (stored == need) begin
            r.status       = ST_COMPLETE;
            r.packet_bytes = stored[15:0];
            restart_hunt();
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    int        bad;
    bad = 0;
    if (rst) begin
      restart_hunt();
      capacity = BUF_SIZE_RESET;
      predicted_echoes.delete();
      mismatches <= 0;
      awaiting   <= 0;
      checked    <= 0;
      completed  <= 0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (in_valid && in_ready) predicted_echoes.push_back(deframe(in_data));
      if (out_valid && out_ready) begin
        got = out_data;
        if (predicted_echoes.size() == 0) begin
          $error("unexpected result: byte_out %0d byte_index %0d status %0d packet_bytes %0d",
                 got.byte_out, got.byte_index, got.status, got.packet_bytes);
          bad++;
        end else begin
          want = predicted_echoes.pop_front();
          if (got.byte_out !== want.byte_out) begin
            $error("byte_out: expected %0d, got %0d", want.byte_out, got.byte_out);
            bad++;
          end
          if (got.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
            bad++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            bad++;
          end
          if (got.packet_bytes !== want.packet_bytes) begin
            $error("packet_bytes: expected %0d, got %0d", want.packet_bytes, got.packet_bytes);
            bad++;
          end
          checked <= checked + 1;
          if (want.status == ST_COMPLETE) completed <= completed + 1;
        end
      end
      mismatches <= mismatches + bad;
      awaiting   <= predicted_echoes.size();
    end
  end

endmodule

/* tb/servo_packet_deframer_top_test.sv */
`timescale 1ns / 1ps

module servo_packet_deframer_top_test;
  import spd_pkg::*;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;
  localparam int   NUM_PHASES   = 10;
  localparam int   CFG_SETTLE   = 4;
  localparam int   END_SETTLE   = 8;
  localparam int   CYCLE_LIMIT  = 300000;
  localparam int   MAX_BODY     = 300;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [15:0] cfg_wdata;

  int mismatches;
  int awaiting;
  int checked;
  int completed;

  bit calm;
  int sent;
  int frames;
  int size_now;

  logic [15:0] size_plan [NUM_PHASES] =
    '{16'd255, 16'hFFFF, 16'd1, 16'd0, 16'd10, 16'd11, 16'd13, 16'd40, 16'd300, 16'd255};
  int quota_plan [NUM_PHASES] = '{250, 250, 40, 40, 200, 150, 150, 250, 300, 250};

  servo_packet_deframer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  servo_packet_deframer_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaiting   (awaiting),
    .checked    (checked),
    .completed  (completed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("** servo_packet_deframer_top: FAILED **");
    $finish;
  end

  // Result side stalls in random bursts unless the run is in a quiet stretch.
  initial begin : sink_stall
    int gap;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && !rst && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic fn, input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: fn, rx_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Holds off the sender until every echo is back and the pipeline is empty.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [15:0] value);
    drain(CFG_SETTLE);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_now = int'(value);
  endtask

  task automatic send_frame();
    int pick;
    int len;
    int total;
    int n;
    bit cut;
    pick = $urandom_range(0, 99);
    if (pick < 50) len = $urandom_range(0, 5);
    else if (pick < 85) len = $urandom_range(6, 40);
    else if (pick < 95) len = $urandom_range(41, MAX_BODY);
    else len = $urandom_range(0, 65535);
    total = ((len < MIN_LENGTH) ? MIN_LENGTH : len) + FRAME_OVERHEAD;
    if (total > MAX_BODY) total = MAX_BODY;
    // Past the capacity only a couple of bytes are worth sending.
    if (total > size_now + 2) total = size_now + 2;
    cut = ($urandom_range(0, 9) == 0);
    if (cut && total > 8) total = $urandom_range(8, total);
    frames++;
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, HDR_FD);
    push_item(FUNC_BYTE, 8'($urandom));
    push_item(FUNC_BYTE, 8'($urandom));
    push_item(FUNC_BYTE, len[7:0]);
    push_item(FUNC_BYTE, len[15:8]);
    for (n = 7; n < total; n++) push_item(FUNC_BYTE, 8'($urandom));
    if (cut) push_item(FUNC_TIMEOUT, 8'($urandom));
  endtask

  task automatic send_noise();
    int pick;
    int n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_item(FUNC_TIMEOUT, 8'($urandom));
    end else if (pick < 50) begin
      for (n = $urandom_range(1, 6); n > 0; n--) begin
        b = 8'($urandom);
        if ($urandom_range(0, 2) == 0) b = HDR_FF;
        else if ($urandom_range(0, 3) == 0) b = HDR_FD;
        push_item(FUNC_BYTE, b);
      end
    end else if (pick < 70) begin
      push_item(FUNC_BYTE, HDR_FF);
      push_item(FUNC_BYTE, 8'($urandom_range(0, 254)));
    end else if (pick < 90) begin
      // A wrong third header byte, an extra FF included.
      b = 8'($urandom);
      if (b == HDR_FD) b = HDR_FF;
      push_item(FUNC_BYTE, HDR_FF);
      push_item(FUNC_BYTE, HDR_FF);
      push_item(FUNC_BYTE, b);
    end else begin
      push_item(FUNC_BYTE, HDR_FF);
      if ($urandom_range(0, 1) == 0) push_item(FUNC_BYTE, HDR_FF);
      push_item(FUNC_TIMEOUT, 8'($urandom));
    end
  endtask

  initial begin
    int p;
    int phase_start;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    calm      = 1'b0;
    sent      = 0;
    frames    = 0;
    size_now  = int'(BUF_SIZE_RESET);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Timeout while hunting, then a mismatch at each header position.
    push_item(FUNC_TIMEOUT, 8'hFF);
    push_item(FUNC_BYTE, 8'h00);
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, 8'h12);
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, 8'h00);
    // A zero length still completes as a ten byte packet.
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, HDR_FD);
    push_item(FUNC_BYTE, 8'h00);
    push_item(FUNC_BYTE, 8'h01);
    push_item(FUNC_BYTE, 8'h00);
    push_item(FUNC_BYTE, 8'h00);
    push_item(FUNC_BYTE, 8'h7F);
    push_item(FUNC_BYTE, 8'h80);
    push_item(FUNC_BYTE, 8'hFF);
    // A timeout in the middle of a packet.
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, HDR_FF);
    push_item(FUNC_BYTE, HDR_FD);
    push_item(FUNC_BYTE, 8'h01);
    push_item(FUNC_TIMEOUT, 8'h00);

    for (p = 0; p < NUM_PHASES; p++) begin
      // The first phase runs on the buffer size left by reset.
      if (p != 0) write_buffer_size(size_plan[p]);
      calm = (p == 4) || (p == NUM_PHASES - 1);
      phase_start = sent;
      while (sent - phase_start < quota_plan[p]) begin
        if ($urandom_range(0, 3) == 0) send_noise();
        else send_frame();
      end
    end

    drain(END_SETTLE);
    $display("Sent %0d items, including %0d framed sequences, over %0d buffer sizes",
             sent, frames, NUM_PHASES);
    $display("Checked %0d echoes; %0d packets completed, sizes 0, 1 and 65535 included",
             checked, completed);
    if (mismatches == 0 && awaiting == 0) begin
      $display("** servo_packet_deframer_top: PASSED **");
    end else begin
      $display("** servo_packet_deframer_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/spd_pkg.sv
design/spd_in_stage.sv
design/spd_core.sv
design/spd_out_stage.sv
design/servo_packet_deframer_top.sv
tb/servo_packet_deframer_checker.sv
tb/servo_packet_deframer_top_test.sv
